// File: design/rvr_pkg.sv
// ----------------------------------------------------------------------------
// rvr_pkg
// Shared types, constants and compare helpers for the raster value
// reclassifier.
// ----------------------------------------------------------------------------
package rvr_pkg;

	localparam int TABLE_ROWS    = 256;
	localparam int FRACTION_BITS = 16;
	localparam int ROW_W         = $clog2(TABLE_ROWS);
	localparam int VAL_W         = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSURE         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_EXTREME = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OTHERS_NA       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT       = 3'd4;

	localparam logic [1:0] MODE_BREAKS = 2'd0;
	localparam logic [1:0] MODE_EXACT  = 2'd1;
	localparam logic [1:0] MODE_RANGE  = 2'd2;

	localparam logic [1:0] CLOS_RIGHT = 2'd0;
	localparam logic [1:0] CLOS_LEFT  = 2'd1;
	localparam logic [1:0] CLOS_BOTH  = 2'd2;

	localparam logic FUNC_LOAD     = 1'b0;
	localparam logic FUNC_CLASSIFY = 1'b1;

	typedef struct packed {
		logic                    nan;
		logic signed [VAL_W-1:0] v;
	} fx_t;

	typedef struct packed {
		fx_t lower;
		fx_t upper;
		fx_t becomes;
	} row_t;

	localparam int ROW_BITS = $bits(row_t);

	typedef struct packed {
		logic [1:0] table_mode;
		logic [1:0] closure;
		logic       include_extreme;
		logic       others_na;
		logic [8:0] row_count;
	} cfg_t;

	typedef struct packed {
		logic             wr;
		logic             start;
		logic             rd_en;
		logic [ROW_W-1:0] rd_addr;
		logic             rd_last;
		logic             finish;
	} ctrl_cmd_t;

	function automatic logic fx_lt(fx_t a, fx_t b);
		return !a.nan && !b.nan && (a.v < b.v);
	endfunction

	function automatic logic fx_le(fx_t a, fx_t b);
		return !a.nan && !b.nan && (a.v <= b.v);
	endfunction

	function automatic logic fx_eq(fx_t a, fx_t b);
		return !a.nan && !b.nan && (a.v == b.v);
	endfunction

	function automatic logic signed [VAL_W-1:0] class_value(logic [ROW_W-1:0] j);
		logic [63:0] s;
		s = 64'(j) << FRACTION_BITS;
		return (s > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : s[VAL_W-1:0];
	endfunction

	function automatic logic [ROW_W-1:0] last_row(logic [8:0] row_count);
		int n;
		n = int'(row_count);
		if (n == 0) n = 1;
		if (n > TABLE_ROWS) n = TABLE_ROWS;
		return ROW_W'(n - 1);
	endfunction

endpackage

// File: design/rvr_if.sv
// ----------------------------------------------------------------------------
// rvr_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rvr_item_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [7:0]         row_index;
	logic signed [31:0] sample_value;
	logic               sample_is_nan;
	logic signed [31:0] upper_value;
	logic               upper_is_nan;
	logic signed [31:0] becomes_value;
	logic               becomes_is_nan;

	modport source(output valid, func, row_index, sample_value, sample_is_nan,
		upper_value, upper_is_nan, becomes_value, becomes_is_nan, input ready);
	modport sink(input valid, func, row_index, sample_value, sample_is_nan,
		upper_value, upper_is_nan, becomes_value, becomes_is_nan, output ready);
endinterface

interface rvr_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               result_is_nan;
	logic               matched;

	modport source(output valid, result_value, result_is_nan, matched, input ready);
	modport sink(input valid, result_value, result_is_nan, matched, output ready);
endinterface

// File: design/rvr_ram.sv
// ----------------------------------------------------------------------------
// rvr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rvr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

// File: design/rvr_ctrl.sv
// ----------------------------------------------------------------------------
// rvr_ctrl
// Sequencer: accepts items, walks the table rows, hands results out.
// ----------------------------------------------------------------------------
module rvr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rvr_pkg::cfg_t          cfg,
	input  logic                   item_valid,
	input  logic                   item_func,
	output logic                   item_ready,
	input  logic                   out_ready,
	output logic                   out_valid,
	output rvr_pkg::ctrl_cmd_t     cmd
);

	typedef enum logic [1:0] {IDLE, SCAN, DRAIN, FINISH} state_t;

	state_t                    state_q;
	logic [rvr_pkg::ROW_W-1:0] cnt_q;
	logic [rvr_pkg::ROW_W-1:0] last_q;
	logic                      out_valid_q;
	logic                      acc;

	assign item_ready = (state_q == IDLE);
	assign acc        = item_valid && item_ready;
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.wr      = acc && (item_func == rvr_pkg::FUNC_LOAD);
		cmd.start   = acc && (item_func == rvr_pkg::FUNC_CLASSIFY);
		cmd.rd_en   = (state_q == SCAN);
		cmd.rd_addr = cnt_q;
		cmd.rd_last = (cnt_q == last_q);
		cmd.finish  = (state_q == FINISH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (cmd.start) begin
						state_q <= SCAN;
						cnt_q   <= '0;
						last_q  <= rvr_pkg::last_row(cfg.row_count);
					end
				end
				SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cmd.rd_last) state_q <= DRAIN;
				end
				DRAIN: begin
					state_q <= FINISH;
				end
				FINISH: begin
					if (cmd.finish) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == SCAN) && (cnt_q == '0))
		else $error("scan did not start at row zero");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SCAN) |-> (cnt_q <= last_q))
		else $error("row counter ran past the last row");

	a_last_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.rd_last) |=> ##1 (state_q == FINISH))
		else $error("finish did not follow the last row read");

endmodule

// File: design/rvr_dpath.sv
// ----------------------------------------------------------------------------
// rvr_dpath
// Row table, per-row compare and accumulate, result selection and register.
// ----------------------------------------------------------------------------
module rvr_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rvr_pkg::cfg_t             cfg,
	input  rvr_pkg::ctrl_cmd_t        cmd,
	input  logic [7:0]                row_index,
	input  logic signed [31:0]        sample_value,
	input  logic                      sample_is_nan,
	input  logic signed [31:0]        upper_value,
	input  logic                      upper_is_nan,
	input  logic signed [31:0]        becomes_value,
	input  logic                      becomes_is_nan,
	output logic signed [31:0]        result_value,
	output logic                      result_is_nan,
	output logic                      matched
);

	rvr_pkg::row_t             wr_row;
	rvr_pkg::row_t             rd_row;
	logic                      wr_en;
	logic                      rd_valid_s1;
	logic                      rd_last_s1;
	logic [rvr_pkg::ROW_W-1:0] idx_s1;

	rvr_pkg::fx_t              x_q;
	rvr_pkg::fx_t              first_q;
	rvr_pkg::fx_t              last_q;
	logic [rvr_pkg::ROW_W-1:0] lastj_q;
	logic                      hit_q;
	logic [rvr_pkg::ROW_W-1:0] hitj_q;
	rvr_pkg::fx_t              hit_rep_q;
	logic                      key_q;
	rvr_pkg::fx_t              key_rep_q;
	rvr_pkg::fx_t              ext_q;
	rvr_pkg::fx_t              ext_rep_q;

	logic signed [31:0]        result_value_q;
	logic                      result_is_nan_q;
	logic                      matched_q;

	rvr_pkg::fx_t lo, up, bec, c;
	logic is_breaks, is_exact, rc, both;
	logic breaks_hit, table_hit, row_hit, key_row, ext_better;
	rvr_pkg::fx_t res;
	logic res_m;
	logic out_low, out_high;

	assign wr_en = cmd.wr && (32'(row_index) < rvr_pkg::TABLE_ROWS);
	assign wr_row.lower   = '{nan: sample_is_nan, v: sample_value};
	assign wr_row.upper   = '{nan: upper_is_nan, v: upper_value};
	assign wr_row.becomes = '{nan: becomes_is_nan, v: becomes_value};

	rvr_ram #(
		.WIDTH(rvr_pkg::ROW_BITS),
		.DEPTH(rvr_pkg::TABLE_ROWS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (rvr_pkg::ROW_W'(row_index)),
		.wdata (wr_row),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr),
		.rdata (rd_row)
	);

	assign lo  = rd_row.lower;
	assign up  = rd_row.upper;
	assign bec = rd_row.becomes;

	assign is_breaks = (cfg.table_mode == rvr_pkg::MODE_BREAKS);
	assign is_exact  = (cfg.table_mode == rvr_pkg::MODE_EXACT);
	assign rc        = (cfg.closure == rvr_pkg::CLOS_RIGHT);
	assign both      = (cfg.closure >= rvr_pkg::CLOS_BOTH);

	always_comb begin
		breaks_hit = rc ? rvr_pkg::fx_le(x_q, lo) : rvr_pkg::fx_lt(x_q, lo);
		if (is_exact)
			table_hit = rvr_pkg::fx_eq(x_q, lo);
		else if (both)
			table_hit = rvr_pkg::fx_le(lo, x_q) && rvr_pkg::fx_le(x_q, up);
		else if (rc)
			table_hit = rvr_pkg::fx_lt(lo, x_q) && rvr_pkg::fx_le(x_q, up);
		else
			table_hit = rvr_pkg::fx_le(lo, x_q) && rvr_pkg::fx_lt(x_q, up);
		row_hit    = is_breaks ? ((idx_s1 != '0) && breaks_hit) : table_hit;
		key_row    = lo.nan || (!is_exact && up.nan);
		c          = rc ? lo : up;
		ext_better = rc ? rvr_pkg::fx_lt(c, ext_q) : rvr_pkg::fx_lt(ext_q, c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
			key_q       <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.start) begin
				hit_q <= 1'b0;
				key_q <= 1'b0;
			end else if (rd_valid_s1) begin
				if (row_hit) hit_q <= 1'b1;
				if (key_row) key_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_last_s1 <= cmd.rd_last;
		idx_s1     <= cmd.rd_addr;
		if (cmd.start) x_q <= '{nan: sample_is_nan, v: sample_value};
		if (rd_valid_s1) begin
			if (idx_s1 == '0) begin
				first_q   <= lo;
				ext_q     <= c;
				ext_rep_q <= bec;
			end else if (ext_better) begin
				ext_q     <= c;
				ext_rep_q <= bec;
			end
			if (rd_last_s1) begin
				last_q  <= lo;
				lastj_q <= idx_s1;
			end
			if (key_row) key_rep_q <= bec;
			if (!hit_q && row_hit) begin
				hitj_q    <= idx_s1;
				hit_rep_q <= bec;
			end
		end
		if (cmd.finish) begin
			result_value_q  <= res.nan ? '0 : res.v;
			result_is_nan_q <= res.nan;
			matched_q       <= res_m;
		end
	end

	always_comb begin
		res      = x_q;
		res_m    = 1'b0;
		out_low  = 1'b0;
		out_high = 1'b0;
		if (is_breaks) begin
			if (rc) begin
				out_low  = cfg.include_extreme ? rvr_pkg::fx_lt(x_q, first_q)
				                               : rvr_pkg::fx_le(x_q, first_q);
				out_high = rvr_pkg::fx_lt(last_q, x_q);
			end else begin
				out_low  = rvr_pkg::fx_lt(x_q, first_q);
				out_high = cfg.include_extreme ? rvr_pkg::fx_lt(last_q, x_q)
				                               : rvr_pkg::fx_le(last_q, x_q);
			end
			if (x_q.nan || out_low || out_high) begin
				res = '{nan: 1'b1, v: '0};
			end else if (!rc && cfg.include_extreme && rvr_pkg::fx_eq(x_q, last_q)) begin
				res   = '{nan: 1'b0, v: rvr_pkg::class_value(lastj_q)};
				res_m = 1'b1;
			end else if (hit_q) begin
				res   = '{nan: 1'b0, v: rvr_pkg::class_value(hitj_q)};
				res_m = 1'b1;
			end
		end else begin
			if (x_q.nan) begin
				res   = key_q ? key_rep_q : '{nan: 1'b1, v: '0};
				res_m = key_q;
			end else if (!is_exact && !both && cfg.include_extreme
			             && rvr_pkg::fx_eq(x_q, ext_q)) begin
				res   = ext_rep_q;
				res_m = 1'b1;
			end else if (hit_q) begin
				res   = hit_rep_q;
				res_m = 1'b1;
			end else if (cfg.others_na) begin
				res = '{nan: 1'b1, v: '0};
			end
		end
	end

	assign result_value  = result_value_q;
	assign result_is_nan = result_is_nan_q;
	assign matched       = matched_q;

endmodule

// File: design/raster_value_reclassifier_top.sv
// ----------------------------------------------------------------------------
// raster_value_reclassifier_top
// Interval-table reclassification of Q16.16 values with NaN flags.
// ----------------------------------------------------------------------------
// Load transaction: written to the row table in the accept cycle.
// Classify transaction: the table read port walks one row per cycle over the n
// rows in use; the result is then registered once the result register is free.
// A new item is accepted only in idle: a load stays idle; a classify returns once its result is registered.
// Reset: configuration to defaults; table rows are undefined until loaded.
// ----------------------------------------------------------------------------
module raster_value_reclassifier_top (
	input  logic                               clk,
	input  logic                               arst_n,
	rvr_item_if.sink                           item,
	rvr_result_if.source                       result,
	input  logic                               cfg_we,
	input  logic [rvr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rvr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	rvr_pkg::cfg_t      cfg_q;
	rvr_pkg::ctrl_cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.table_mode      <= rvr_pkg::MODE_RANGE;
			cfg_q.closure         <= rvr_pkg::CLOS_RIGHT;
			cfg_q.include_extreme <= 1'b0;
			cfg_q.others_na       <= 1'b0;
			cfg_q.row_count       <= 9'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rvr_pkg::CFG_TABLE_MODE:      cfg_q.table_mode      <= cfg_data[1:0];
				rvr_pkg::CFG_CLOSURE:         cfg_q.closure         <= cfg_data[1:0];
				rvr_pkg::CFG_INCLUDE_EXTREME: cfg_q.include_extreme <= cfg_data[0];
				rvr_pkg::CFG_OTHERS_NA:       cfg_q.others_na       <= cfg_data[0];
				rvr_pkg::CFG_ROW_COUNT:       cfg_q.row_count       <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	rvr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item.valid),
		.item_func  (item.func),
		.item_ready (item.ready),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.cmd        (cmd)
	);

	rvr_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.row_index      (item.row_index),
		.sample_value   (item.sample_value),
		.sample_is_nan  (item.sample_is_nan),
		.upper_value    (item.upper_value),
		.upper_is_nan   (item.upper_is_nan),
		.becomes_value  (item.becomes_value),
		.becomes_is_nan (item.becomes_is_nan),
		.result_value   (result.result_value),
		.result_is_nan  (result.result_is_nan),
		.matched        (result.matched)
	);

endmodule
